FILE: rtl/macl_pkg.sv
// shared types, constants and field layouts of the mac access list filter
// no dependencies; imported by every module of the block but macl_ram

package macl_pkg;

  localparam int unsigned TABLE_ENTRIES = 80;
  localparam int unsigned LANES         = 8;
  localparam int unsigned LANE_W        = $clog2(LANES);
  localparam int unsigned ROWS          = (TABLE_ENTRIES + LANES - 1) / LANES;
  localparam int unsigned ROW_W         = (ROWS > 1) ? $clog2(ROWS) : 1;

  localparam int unsigned IDX_W  = 7;
  localparam int unsigned MAC_W  = 48;

  localparam int unsigned S_TDATA_W = 160;
  localparam int unsigned M_TDATA_W = 8;

  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 2;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [15:0] DHCP_SERVER_PORT = 16'h0043;
  localparam logic [15:0] DHCP_CLIENT_PORT = 16'h0044;
  localparam logic [15:0] ETYPE_IPV4       = 16'h0800;
  localparam logic [15:0] ETYPE_ARP        = 16'h0806;
  localparam logic [15:0] ETYPE_RARP       = 16'h8035;
  localparam logic [7:0]  PROTO_UDP        = 8'd17;

  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_CHECK = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_LIST_MODE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_BYPASS    = 1'b1;

  typedef enum logic [1:0] {
    LM_UNSET   = 2'd0,
    LM_WHITE   = 2'd1,
    LM_BLACK   = 2'd2,
    LM_INVALID = 2'd3
  } list_mode_e;

  // input tdata layout, lowest field last
  typedef struct packed {
    logic [15:0]      udp_dst_port;
    logic [15:0]      udp_src_port;
    logic [7:0]       ip_protocol;
    logic [15:0]      ethertype;
    logic             from_checked_port;
    logic [MAC_W-1:0] src_mac;
    logic [MAC_W-1:0] entry_mac;
    logic [IDX_W-1:0] entry_index;
  } s_data_t;

  // classified command passed from front to back
  typedef struct packed {
    logic             is_check;
    logic [ROW_W-1:0] row;
    logic [LANE_W-1:0] lane;
    logic [MAC_W-1:0] mac;
    logic             checked;
    logic             bypass_type;
  } cmd_t;

endpackage

FILE: rtl/macl_ram.sv
// generic single write port ram with registered read
// no dependencies; used for the mac table banks

module macl_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/macl_front.sv
// front stage: accepts items, classifies them and drops out of range writes
// depends on macl_pkg

module macl_front import macl_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [S_TDATA_W-1:0] in_data_i,
  input  logic                 in_mode_i,
  output logic                 cmd_valid_o,
  input  logic                 cmd_ready_i,
  output cmd_t                 cmd_o
);

  s_data_t f;
  cmd_t    cmd_d, cmd_q;
  logic    valid_d, valid_q;
  logic    accept, keep, bypass_type;

  assign f          = s_data_t'(in_data_i);
  assign in_ready_o = !valid_q || cmd_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign keep       = (in_mode_i == MODE_CHECK) || (32'(f.entry_index) < TABLE_ENTRIES);

  assign bypass_type = (f.ethertype == ETYPE_ARP) || (f.ethertype == ETYPE_RARP) ||
                       ((f.ethertype == ETYPE_IPV4) && (f.ip_protocol == PROTO_UDP) &&
                        (f.udp_src_port == DHCP_CLIENT_PORT) &&
                        (f.udp_dst_port == DHCP_SERVER_PORT));

  always_comb begin
    cmd_d             = cmd_q;
    valid_d           = valid_q && !cmd_ready_i;
    if (accept) begin
      valid_d           = keep;
      cmd_d.is_check    = (in_mode_i == MODE_CHECK);
      cmd_d.row         = ROW_W'(f.entry_index >> LANE_W);
      cmd_d.lane        = f.entry_index[LANE_W-1:0];
      cmd_d.mac         = (in_mode_i == MODE_CHECK) ? f.src_mac : f.entry_mac;
      cmd_d.checked     = f.from_checked_port;
      cmd_d.bypass_type = bypass_type;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      cmd_q   <= '0;
    end else begin
      valid_q <= valid_d;
      cmd_q   <= cmd_d;
    end
  end

  assign cmd_valid_o = valid_q;
  assign cmd_o       = cmd_q;

endmodule

FILE: rtl/macl_fifo.sv
// short command queue between the front and back stages
// depends on macl_pkg

module macl_fifo import macl_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_valid_i,
  output logic push_ready_o,
  input  cmd_t push_cmd_i,
  output logic pop_valid_o,
  input  logic pop_ready_i,
  output cmd_t pop_cmd_o
);

  cmd_t              entry_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] count_q;
  logic              push, pop;

  assign push_ready_o = (32'(count_q) != QUEUE_DEPTH);
  assign pop_valid_o  = (count_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_cmd_o    = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
        entry_q[i] <= '0;
      end
    end else begin
      if (push) begin
        entry_q[wr_ptr_q] <= push_cmd_i;
        wr_ptr_q <= (32'(wr_ptr_q) == QUEUE_DEPTH - 1) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (32'(rd_ptr_q) == QUEUE_DEPTH - 1) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        count_q <= count_q + 1'b1;
      end else if (pop && !push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

FILE: rtl/macl_back.sv
// back stage: table writes, banked table search and drop decision
// depends on macl_pkg and macl_ram

module macl_back import macl_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cmd_valid_i,
  output logic       cmd_ready_o,
  input  cmd_t       cmd_i,
  input  list_mode_e list_mode_i,
  input  logic       bypass_en_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       out_drop_o,
  output logic       out_listed_o,
  output logic       loaded_o
);

  typedef enum logic [1:0] {ST_IDLE, ST_SEARCH, ST_RESULT} state_e;

  state_e           state_q;
  cmd_t             cmd_q;
  logic [LANES-1:0] valid_q [ROWS];
  logic             loaded_q;
  logic [ROW_W-1:0] issue_row_q, cmp_row_q;
  logic             issue_done_q, cmp_vld_q, hit_q;
  logic             out_valid_q, out_drop_q, out_listed_q;

  logic [MAC_W-1:0] rd_data [LANES];
  logic [LANES-1:0] lane_match;
  logic             pop, row_hit, want_drop, out_free;

  assign cmd_ready_o = (state_q == ST_IDLE);
  assign pop         = cmd_valid_i && cmd_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;

  for (genvar l = 0; l < LANES; l++) begin : g_bank
    macl_ram #(.WIDTH(MAC_W), .DEPTH(ROWS)) u_bank (
      .clk_i   (clk_i),
      .we_i    (pop && !cmd_i.is_check && (cmd_i.lane == LANE_W'(l))),
      .waddr_i (cmd_i.row),
      .wdata_i (cmd_i.mac),
      .raddr_i (issue_row_q),
      .rdata_o (rd_data[l])
    );
    assign lane_match[l] = (rd_data[l] == cmd_q.mac);
  end

  assign row_hit = cmp_vld_q && |(lane_match & valid_q[cmp_row_q]);

  always_comb begin
    want_drop = ((list_mode_i == LM_WHITE) && !hit_q) ||
                ((list_mode_i == LM_BLACK) && hit_q);
    if (!loaded_q || !cmd_q.checked) begin
      want_drop = 1'b0;
    end
    if (bypass_en_i && cmd_q.bypass_type) begin
      want_drop = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      cmd_q        <= '0;
      loaded_q     <= 1'b0;
      issue_row_q  <= '0;
      cmp_row_q    <= '0;
      issue_done_q <= 1'b0;
      cmp_vld_q    <= 1'b0;
      hit_q        <= 1'b0;
      out_valid_q  <= 1'b0;
      out_drop_q   <= 1'b0;
      out_listed_q <= 1'b0;
      for (int r = 0; r < ROWS; r++) begin
        valid_q[r] <= '0;
      end
    end else begin
      if (out_valid_q && out_ready_i && (state_q != ST_RESULT)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (pop) begin
            if (cmd_i.is_check) begin
              cmd_q        <= cmd_i;
              issue_row_q  <= '0;
              issue_done_q <= 1'b0;
              cmp_vld_q    <= 1'b0;
              hit_q        <= 1'b0;
              state_q      <= ST_SEARCH;
            end else begin
              valid_q[cmd_i.row][cmd_i.lane] <= 1'b1;
              loaded_q <= 1'b1;
            end
          end
        end
        ST_SEARCH: begin
          // read of row n overlaps compare of row n-1
          cmp_vld_q <= !issue_done_q;
          cmp_row_q <= issue_row_q;
          if (!issue_done_q) begin
            if (32'(issue_row_q) == ROWS - 1) begin
              issue_done_q <= 1'b1;
            end else begin
              issue_row_q <= issue_row_q + 1'b1;
            end
          end
          hit_q <= hit_q || row_hit;
          if (cmp_vld_q && (32'(cmp_row_q) == ROWS - 1)) begin
            state_q <= ST_RESULT;
          end
        end
        ST_RESULT: begin
          if (out_free) begin
            out_valid_q  <= 1'b1;
            out_drop_q   <= want_drop;
            out_listed_q <= hit_q;
            state_q      <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_drop_o   = out_drop_q;
  assign out_listed_o = out_listed_q;
  assign loaded_o     = loaded_q;

endmodule

FILE: rtl/mac_access_list_packet_filter_core.sv
// top level of the mac access list filter: config registers and stage wiring
// depends on macl_pkg, macl_front, macl_fifo, macl_back
//
//   port group  dir  handshake                    content
//   s_axis      in   s_axis_tvalid/s_axis_tready  table write or packet check item
//   m_axis      out  m_axis_tvalid/m_axis_tready  drop decision item, one per check
//   cfg         in   cfg_we_i                     list_mode, bypass_enable
//
// a table write is done in the idle state of the back stage; a packet check sweeps every
// row of the eight table banks, read one row a cycle
// the front register and a two-entry queue keep accepting while the back stage searches
// reset clears all valid marks at once; no clearing pass, items accepted right after reset
// a stalled result holds in the output register while the next check is searched

module mac_access_list_packet_filter_core import macl_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // entry_index, entry_mac, src_mac, from_checked_port, ethertype, ip_protocol,
  // udp_src_port, udp_dst_port
  input  logic [S_TDATA_W-1:0]  s_axis_tdata,
  // mode
  input  logic                  s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // drop, listed, zero fill
  output logic [M_TDATA_W-1:0]  m_axis_tdata,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  list_mode_e list_mode_q;
  logic       bypass_en_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      list_mode_q <= LM_UNSET;
      bypass_en_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_LIST_MODE: list_mode_q <= list_mode_e'(cfg_data_i[1:0]);
        REG_BYPASS:    bypass_en_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  logic cmd_valid, cmd_ready, q_valid, q_ready;
  cmd_t cmd, q_cmd;
  logic drop, listed, table_loaded;

  macl_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_data_i   (s_axis_tdata),
    .in_mode_i   (s_axis_tuser),
    .cmd_valid_o (cmd_valid),
    .cmd_ready_i (cmd_ready),
    .cmd_o       (cmd)
  );

  macl_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (cmd_valid),
    .push_ready_o (cmd_ready),
    .push_cmd_i   (cmd),
    .pop_valid_o  (q_valid),
    .pop_ready_i  (q_ready),
    .pop_cmd_o    (q_cmd)
  );

  macl_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_valid_i  (q_valid),
    .cmd_ready_o  (q_ready),
    .cmd_i        (q_cmd),
    .list_mode_i  (list_mode_q),
    .bypass_en_i  (bypass_en_q),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_drop_o   (drop),
    .out_listed_o (listed),
    .loaded_o     (table_loaded)
  );

  assign m_axis_tdata = {(M_TDATA_W - 2)'(0), listed, drop};

  a_drop_needs_list: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && drop |->
      (list_mode_q == LM_WHITE && !listed) || (list_mode_q == LM_BLACK && listed))
    else $error("drop disagrees with list mode and match");

  a_drop_needs_table: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && drop |-> table_loaded)
    else $error("drop with no table entry loaded");

  a_listed_needs_table: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && listed |-> table_loaded)
    else $error("match reported with empty table");

endmodule

FILE: bench/tb_top.sv
// self-checking bench for mac_access_list_packet_filter_core: directed acl cases, then random traffic
// predicts each drop decision from its own copy of the mac table and registers
// depends on macl_pkg and the rtl of the filter core

module tb_top;
  import macl_pkg::*;

  localparam int CLK_PERIOD       = 8;
  localparam int DRAIN_CYCLES     = 48;
  localparam int TIMEOUT_CYCLES   = 400000;
  localparam int ITEMS_PER_SEGMENT = 77;
  localparam logic [15:0] ETYPE_IPV6 = 16'h86dd;
  localparam logic [7:0]  PROTO_TCP  = 8'd6;

  typedef struct packed {
    logic listed;
    logic drop;
  } decision_t;

  logic                  clk_i;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [S_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                  s_axis_tuser = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0]  m_axis_tdata;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  // filter state as the bench sees it
  logic [MAC_W-1:0] slot_mac [TABLE_ENTRIES];
  logic             slot_valid [TABLE_ENTRIES];
  logic             table_loaded;
  list_mode_e       acl_mode;
  logic             bypass_on;

  decision_t pending_decisions [$];

  int idle_pct  = 0;
  int stall_pct = 0;
  int n_writes  = 0;
  int n_checks  = 0;
  int n_drops   = 0;
  int n_listed  = 0;
  int n_errors  = 0;

  mac_access_list_packet_filter_core uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    n_errors++;
  endtask

  function automatic decision_t predict_decision(input s_data_t d);
    decision_t r;
    logic      bypass_kind;
    r.listed = 1'b0;
    foreach (slot_valid[k]) begin
      if (slot_valid[k] && slot_mac[k] == d.src_mac) r.listed = 1'b1;
    end
    case (acl_mode)
      LM_WHITE: r.drop = !r.listed;
      LM_BLACK: r.drop = r.listed;
      default:  r.drop = 1'b0;
    endcase
    if (!table_loaded || !d.from_checked_port) r.drop = 1'b0;
    bypass_kind = (d.ethertype == ETYPE_ARP) || (d.ethertype == ETYPE_RARP) ||
                  (d.ethertype == ETYPE_IPV4 && d.ip_protocol == PROTO_UDP &&
                   d.udp_src_port == DHCP_CLIENT_PORT && d.udp_dst_port == DHCP_SERVER_PORT);
    if (bypass_on && bypass_kind) r.drop = 1'b0;
    return r;
  endfunction

  function automatic s_data_t random_fields();
    return s_data_t'({$urandom(), $urandom(), $urandom(), $urandom(), $urandom()});
  endfunction

  function automatic s_data_t write_item(input int idx, input logic [MAC_W-1:0] mac);
    s_data_t d;
    d = random_fields();
    d.entry_index = IDX_W'(idx);
    d.entry_mac   = mac;
    return d;
  endfunction

  function automatic s_data_t check_item(input logic [MAC_W-1:0] mac, input logic checked,
                                         input logic [15:0] etype, input logic [7:0] proto,
                                         input logic [15:0] sport, input logic [15:0] dport);
    s_data_t d;
    d = random_fields();
    d.src_mac           = mac;
    d.from_checked_port = checked;
    d.ethertype         = etype;
    d.ip_protocol       = proto;
    d.udp_src_port      = sport;
    d.udp_dst_port      = dport;
    return d;
  endfunction

  task automatic send_item(input logic mode, input s_data_t d);
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= d;
    s_axis_tuser  <= mode;
    do @(posedge clk_i); while (!s_axis_tready);
    if (mode == MODE_CHECK) begin
      decision_t r;
      r = predict_decision(d);
      pending_decisions.push_back(r);
      n_checks++;
      n_drops  += r.drop;
      n_listed += r.listed;
    end else begin
      n_writes++;
      if (d.entry_index < TABLE_ENTRIES) begin
        slot_mac[d.entry_index]   = d.entry_mac;
        slot_valid[d.entry_index] = 1'b1;
        table_loaded              = 1'b1;
      end
    end
  endtask

  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (pending_decisions.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] val);
    settle();
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_LIST_MODE) acl_mode = list_mode_e'(val);
    else if (idx == REG_BYPASS) bypass_on = val[0];
  endtask

  // receiver side stalls
  always @(posedge clk_i) m_axis_tready <= ($urandom_range(99) >= stall_pct);

  always @(posedge clk_i) begin
    decision_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_decisions.size() == 0) begin
        report_mismatch($sformatf("unexpected result tdata=%h", m_axis_tdata));
      end else begin
        want = pending_decisions.pop_front();
        if (m_axis_tdata[0] !== want.drop)
          report_mismatch($sformatf("drop got %b want %b", m_axis_tdata[0], want.drop));
        if (m_axis_tdata[1] !== want.listed)
          report_mismatch($sformatf("listed got %b want %b", m_axis_tdata[1], want.listed));
      end
    end
  end

  task automatic test_pass_before_load();
    send_item(MODE_CHECK, check_item('0, 1'b1, ETYPE_IPV4, PROTO_TCP, 16'h0, 16'hffff));
    write_register(REG_LIST_MODE, LM_WHITE);
    send_item(MODE_CHECK, check_item(48'h0000_0000_0001, 1'b1, ETYPE_IPV6, PROTO_TCP,
                                     16'hffff, 16'h0));
    // out of range slots leave the table unloaded
    send_item(MODE_WRITE, write_item(TABLE_ENTRIES, 48'h0000_0000_0001));
    send_item(MODE_WRITE, write_item(127, '1));
    send_item(MODE_CHECK, check_item(48'h0000_0000_0001, 1'b1, 16'hffff, 8'hff,
                                     16'h0, 16'h0));
  endtask

  task automatic test_whitelist();
    send_item(MODE_WRITE, write_item(0, '0));
    send_item(MODE_WRITE, write_item(TABLE_ENTRIES - 1, '1));
    send_item(MODE_CHECK, check_item('0, 1'b1, ETYPE_IPV4, PROTO_TCP, 16'h1, 16'h2));
    send_item(MODE_CHECK, check_item('1, 1'b1, ETYPE_IPV4, PROTO_TCP, 16'h1, 16'h2));
    send_item(MODE_CHECK, check_item(48'h0012_3456_789a, 1'b1, ETYPE_IPV6, 8'h0,
                                     16'h0, 16'h0));
    send_item(MODE_CHECK, check_item(48'h0012_3456_789a, 1'b0, ETYPE_IPV6, 8'h0,
                                     16'h0, 16'h0));
  endtask

  task automatic test_slot_rewrite();
    send_item(MODE_WRITE, write_item(0, 48'h0123_4567_89ab));
    send_item(MODE_CHECK, check_item('0, 1'b1, ETYPE_IPV6, PROTO_TCP, 16'h0, 16'h0));
    send_item(MODE_CHECK, check_item(48'h0123_4567_89ab, 1'b1, ETYPE_IPV6, PROTO_TCP,
                                     16'h0, 16'h0));
  endtask

  task automatic test_bypass();
    write_register(REG_BYPASS, 1'b1);
    send_item(MODE_CHECK, check_item(48'h00aa_bbcc_ddee, 1'b1, ETYPE_ARP, PROTO_TCP,
                                     16'h0, 16'h0));
    send_item(MODE_CHECK, check_item(48'h00aa_bbcc_ddee, 1'b1, ETYPE_RARP, PROTO_TCP,
                                     16'h0, 16'h0));
    send_item(MODE_CHECK, check_item(48'h00aa_bbcc_ddee, 1'b1, ETYPE_IPV4, PROTO_UDP,
                                     DHCP_CLIENT_PORT, DHCP_SERVER_PORT));
    send_item(MODE_CHECK, check_item(48'h00aa_bbcc_ddee, 1'b1, ETYPE_IPV4, PROTO_UDP,
                                     DHCP_SERVER_PORT, DHCP_CLIENT_PORT));
    send_item(MODE_CHECK, check_item(48'h00aa_bbcc_ddee, 1'b1, ETYPE_IPV4, PROTO_TCP,
                                     DHCP_CLIENT_PORT, DHCP_SERVER_PORT));
    send_item(MODE_CHECK, check_item('1, 1'b1, ETYPE_ARP, PROTO_UDP, 16'h0, 16'h0));
  endtask

  task automatic test_blacklist();
    write_register(REG_LIST_MODE, LM_BLACK);
    send_item(MODE_CHECK, check_item('1, 1'b1, ETYPE_ARP, PROTO_UDP, 16'h0, 16'h0));
    write_register(REG_BYPASS, 1'b0);
    send_item(MODE_CHECK, check_item('1, 1'b1, ETYPE_ARP, PROTO_UDP, 16'h0, 16'h0));
    send_item(MODE_CHECK, check_item(48'h00aa_bbcc_ddee, 1'b1, ETYPE_IPV4, PROTO_UDP,
                                     16'h0, 16'h0));
  endtask

  task automatic test_invalid_mode();
    write_register(REG_LIST_MODE, LM_INVALID);
    send_item(MODE_CHECK, check_item('1, 1'b1, ETYPE_IPV4, PROTO_TCP, 16'h0, 16'h0));
    write_register(REG_LIST_MODE, LM_UNSET);
    send_item(MODE_CHECK, check_item('1, 1'b1, ETYPE_IPV4, PROTO_TCP, 16'h0, 16'h0));
  endtask

  task automatic send_random_item();
    s_data_t     d;
    int unsigned pick;
    int unsigned k;
    d = random_fields();
    if ($urandom_range(99) < 25) begin
      if ($urandom_range(9) == 0) d.entry_index = IDX_W'($urandom_range(127, TABLE_ENTRIES));
      else d.entry_index = IDX_W'($urandom_range(TABLE_ENTRIES - 1));
      send_item(MODE_WRITE, d);
    end else begin
      pick = $urandom_range(99);
      k    = $urandom_range(TABLE_ENTRIES - 1);
      if (pick < 45 && slot_valid[k]) d.src_mac = slot_mac[k];
      else if (pick < 60 && slot_valid[k])
        d.src_mac = slot_mac[k] ^ (48'd1 << $urandom_range(MAC_W - 1));
      d.from_checked_port = ($urandom_range(9) != 0);
      case ($urandom_range(4))
        0:       d.ethertype = ETYPE_ARP;
        1:       d.ethertype = ETYPE_RARP;
        2, 3:    d.ethertype = ETYPE_IPV4;
        default: ;
      endcase
      if ($urandom_range(1)) d.ip_protocol = PROTO_UDP;
      case ($urandom_range(3))
        0: begin
          d.udp_src_port = DHCP_CLIENT_PORT;
          d.udp_dst_port = DHCP_SERVER_PORT;
        end
        1: begin
          d.udp_src_port = DHCP_SERVER_PORT;
          d.udp_dst_port = DHCP_CLIENT_PORT;
        end
        default: ;
      endcase
      send_item(MODE_CHECK, d);
    end
  endtask

  task automatic test_random_traffic();
    for (int phase = 0; phase < 4; phase++) begin
      for (int seg = 0; seg < 3; seg++) begin
        write_register(REG_LIST_MODE, CFG_DATA_W'((phase * 3 + seg) % 4));
        write_register(REG_BYPASS, CFG_DATA_W'($urandom_range(3)));
        case (phase)
          0: begin idle_pct = 0;  stall_pct = 0;  end
          1: begin idle_pct = 46; stall_pct = 0;  end
          2: begin idle_pct = 0;  stall_pct = 46; end
          default: begin idle_pct = 28; stall_pct = 28; end
        endcase
        repeat (ITEMS_PER_SEGMENT) send_random_item();
      end
    end
  endtask

  initial begin
    foreach (slot_valid[k]) slot_valid[k] = 1'b0;
    table_loaded = 1'b0;
    acl_mode     = LM_UNSET;
    bypass_on    = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_pass_before_load();
    test_whitelist();
    test_slot_rewrite();
    test_bypass();
    test_blacklist();
    test_invalid_mode();
    test_random_traffic();
    settle();
    $display("sent %0d table writes and %0d packet checks (%0d dropped, %0d listed)",
             n_writes, n_checks, n_drops, n_listed);
    $display("all list modes and bypass settings, with and without idle and stall gaps");
    if (n_errors == 0) begin
      $display("** mac_access_list_packet_filter_core: PASSED **");
    end else begin
      $display("** mac_access_list_packet_filter_core: FAILED **");
    end
    $finish;
  end

  initial begin
    #(CLK_PERIOD * TIMEOUT_CYCLES);
    $display("timeout with %0d results outstanding", pending_decisions.size());
    $display("** mac_access_list_packet_filter_core: FAILED **");
    $finish;
  end

endmodule
